// ----- design/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, register indexes and payload types of the ray/triangle
// intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

   // Coordinate format and internal widths.
   localparam int COORD_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int EDGE_W     = COORD_W + 1;
   localparam int PP_W       = 2 * EDGE_W;
   localparam int CROSS_W    = PP_W + 1;
   localparam int SPLIT      = 34;
   localparam int HIGH_W     = CROSS_W - SPLIT;
   localparam int LO_W       = EDGE_W + SPLIT + 1;
   localparam int HI_W       = EDGE_W + HIGH_W;
   localparam int SUMLO_W    = LO_W + 2;
   localparam int SUMHI_W    = HI_W + 2;
   localparam int DOT_W      = 104;
   localparam int ABS_W      = DOT_W - 1;
   localparam int EPS_W      = 63;
   localparam int Q_W        = COORD_W - 1;
   localparam int SAT_SHIFT  = Q_W - FRAC_BITS;
   localparam int SAT_W      = ABS_W + SAT_SHIFT;
   localparam int DIV_STAGES = Q_W;
   localparam int CSR_IDX_W  = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS   = 3'd6;

   // Reset values of the ray registers.
   localparam logic [COORD_W-1:0] DIR_Z_RESET = 32'h0001_0000;
   localparam logic [EPS_W-1:0]   EPS_RESET   = 63'd281475;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [CROSS_W-1:0] cross_type;

   typedef struct packed {
      coord_type vert_a_x;
      coord_type vert_a_y;
      coord_type vert_a_z;
      coord_type vert_b_x;
      coord_type vert_b_y;
      coord_type vert_b_z;
      coord_type vert_c_x;
      coord_type vert_c_y;
      coord_type vert_c_z;
   } req_type;

   typedef struct packed {
      logic           hit;
      logic [Q_W-1:0] hit_distance;
   } rsp_type;

   // Ray held in configuration registers, index 0..2 is x..z.
   typedef struct packed {
      coord_type [2:0] org;
      coord_type [2:0] dir;
   } ray_type;

   // Edges, origin offset and the two cross products.
   typedef struct packed {
      edge_type  [2:0] e1;
      edge_type  [2:0] e2;
      edge_type  [2:0] tv;
      cross_type [2:0] p;
      cross_type [2:0] q;
   } geom_type;

   // State that travels through the quotient stages.
   typedef struct packed {
      logic             miss;
      logic             sat;
      logic [ABS_W-1:0] adet;
      logic [ABS_W-1:0] rem;
      logic [Q_W-1:0]   low;
   } div_type;

endpackage

// ----- design/rti_cross.sv -----
// ----------------------------------------------------------------------------
// rti_cross
// Edge vectors and the cross products P = dir x e2 and Q = tv x e1,
// in three register stages.
// ----------------------------------------------------------------------------
module rti_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rti_pkg::req_type   in_data,
   input  rti_pkg::ray_type   ray,
   output logic               out_valid,
   output rti_pkg::geom_type  out_data
);

   rti_pkg::coord_type va [3];
   rti_pkg::coord_type vb [3];
   rti_pkg::coord_type vc [3];

   rti_pkg::edge_type e1_in [3];
   rti_pkg::edge_type e2_in [3];
   rti_pkg::edge_type tv_in [3];
   rti_pkg::edge_type e1_ff [3];
   rti_pkg::edge_type e2_ff [3];
   rti_pkg::edge_type tv_ff [3];
   rti_pkg::edge_type e1_2_ff [3];
   rti_pkg::edge_type e2_2_ff [3];
   rti_pkg::edge_type tv_2_ff [3];

   logic signed [rti_pkg::PP_W-1:0] pp_in [6];
   logic signed [rti_pkg::PP_W-1:0] qp_in [6];
   logic signed [rti_pkg::PP_W-1:0] pp_ff [6];
   logic signed [rti_pkg::PP_W-1:0] qp_ff [6];

   rti_pkg::geom_type geom_in;
   rti_pkg::geom_type geom_ff;

   logic v1_ff;
   logic v2_ff;
   logic v3_ff;

   // Vertex components as arrays.
   always_comb begin
      va[0] = in_data.vert_a_x;
      va[1] = in_data.vert_a_y;
      va[2] = in_data.vert_a_z;
      vb[0] = in_data.vert_b_x;
      vb[1] = in_data.vert_b_y;
      vb[2] = in_data.vert_b_z;
      vc[0] = in_data.vert_c_x;
      vc[1] = in_data.vert_c_y;
      vc[2] = in_data.vert_c_z;
   end

   // Stage 1: edges and the origin offset, exact in one extra bit.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = rti_pkg::EDGE_W'(vb[i]) - rti_pkg::EDGE_W'(va[i]);
         e2_in[i] = rti_pkg::EDGE_W'(vc[i]) - rti_pkg::EDGE_W'(va[i]);
         tv_in[i] = rti_pkg::EDGE_W'($signed(ray.org[i])) - rti_pkg::EDGE_W'(va[i]);
      end
   end

   // Stage 2: the twelve partial products of both cross products.
   always_comb begin
      pp_in[0] = $signed(ray.dir[1]) * e2_ff[2];
      pp_in[1] = $signed(ray.dir[2]) * e2_ff[1];
      pp_in[2] = $signed(ray.dir[2]) * e2_ff[0];
      pp_in[3] = $signed(ray.dir[0]) * e2_ff[2];
      pp_in[4] = $signed(ray.dir[0]) * e2_ff[1];
      pp_in[5] = $signed(ray.dir[1]) * e2_ff[0];
      qp_in[0] = tv_ff[1] * e1_ff[2];
      qp_in[1] = tv_ff[2] * e1_ff[1];
      qp_in[2] = tv_ff[2] * e1_ff[0];
      qp_in[3] = tv_ff[0] * e1_ff[2];
      qp_in[4] = tv_ff[0] * e1_ff[1];
      qp_in[5] = tv_ff[1] * e1_ff[0];
   end

   // Stage 3: differences that complete P and Q.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         geom_in.e1[i] = e1_2_ff[i];
         geom_in.e2[i] = e2_2_ff[i];
         geom_in.tv[i] = tv_2_ff[i];
         geom_in.p[i]  = rti_pkg::CROSS_W'(pp_ff[2*i]) - rti_pkg::CROSS_W'(pp_ff[2*i+1]);
         geom_in.q[i]  = rti_pkg::CROSS_W'(qp_ff[2*i]) - rti_pkg::CROSS_W'(qp_ff[2*i+1]);
      end
   end

   // Data registers advance with the pipeline enable.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]   <= e1_in[i];
            e2_ff[i]   <= e2_in[i];
            tv_ff[i]   <= tv_in[i];
            e1_2_ff[i] <= e1_ff[i];
            e2_2_ff[i] <= e2_ff[i];
            tv_2_ff[i] <= tv_ff[i];
         end
         for (int k = 0; k < 6; k++) begin
            pp_ff[k] <= pp_in[k];
            qp_ff[k] <= qp_in[k];
         end
         geom_ff <= geom_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = geom_ff;

endmodule

// ----- design/rti_dot.sv -----
// ----------------------------------------------------------------------------
// rti_dot
// Dot products for det, u, v and t numerators, sign normalization and the
// exact miss tests, in five register stages.
// ----------------------------------------------------------------------------
module rti_dot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rti_pkg::geom_type             in_data,
   input  rti_pkg::ray_type              ray,
   input  logic [rti_pkg::EPS_W-1:0]     eps,
   output logic                          out_valid,
   output rti_pkg::div_type              out_data
);

   // Operand index: 0 det, 1 u, 2 v, 3 t.
   rti_pkg::edge_type  lhs [4][3];
   rti_pkg::cross_type rhs [4][3];

   logic signed [rti_pkg::LO_W-1:0]    lo_in  [4][3];
   logic signed [rti_pkg::HI_W-1:0]    hi_in  [4][3];
   logic signed [rti_pkg::LO_W-1:0]    lo_ff  [4][3];
   logic signed [rti_pkg::HI_W-1:0]    hi_ff  [4][3];
   logic signed [rti_pkg::SUMLO_W-1:0] slo_ff [4];
   logic signed [rti_pkg::SUMHI_W-1:0] shi_ff [4];
   logic signed [rti_pkg::DOT_W-1:0]   dot_ff [4];

   logic                             neg;
   logic signed [rti_pkg::DOT_W-1:0] abs_det;
   logic [rti_pkg::ABS_W-1:0]        adet_ff;
   logic signed [rti_pkg::DOT_W-1:0] un_ff;
   logic signed [rti_pkg::DOT_W-1:0] vn_ff;
   logic signed [rti_pkg::DOT_W-1:0] tn_ff;
   logic                             degen_in;
   logic                             degen_ff;

   logic signed [rti_pkg::DOT_W-1:0] adet_s;
   logic signed [rti_pkg::DOT_W:0]   uv_sum;
   rti_pkg::div_type                 div_in;
   rti_pkg::div_type                 div_ff;

   logic [4:0] v_ff;

   // Operand routing for the four dot products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lhs[0][i] = in_data.e1[i];
         rhs[0][i] = in_data.p[i];
         lhs[1][i] = in_data.tv[i];
         rhs[1][i] = in_data.p[i];
         lhs[2][i] = rti_pkg::EDGE_W'($signed(ray.dir[i]));
         rhs[2][i] = in_data.q[i];
         lhs[3][i] = in_data.e2[i];
         rhs[3][i] = in_data.q[i];
      end
   end

   // Stage 4: each wide product as a low (unsigned part) and a high product.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            lo_in[k][i] = lhs[k][i] * $signed({1'b0, rhs[k][i][rti_pkg::SPLIT-1:0]});
            hi_in[k][i] = lhs[k][i] *
                          $signed(rhs[k][i][rti_pkg::CROSS_W-1:rti_pkg::SPLIT]);
         end
      end
   end

   // Stage 7 logic: normalize by the sign of det.
   always_comb begin
      neg      = dot_ff[0][rti_pkg::DOT_W-1];
      abs_det  = neg ? -dot_ff[0] : dot_ff[0];
      degen_in = (abs_det == '0) ||
                 (rti_pkg::ABS_W'(abs_det) < rti_pkg::ABS_W'(eps));
   end

   // Stage 8 logic: bounds on u, v and t, saturation, divider seed.
   always_comb begin
      adet_s      = $signed({1'b0, adet_ff});
      uv_sum      = (rti_pkg::DOT_W+1)'(un_ff) + (rti_pkg::DOT_W+1)'(vn_ff);
      div_in.miss = degen_ff || un_ff[rti_pkg::DOT_W-1] || (un_ff > adet_s) ||
                    vn_ff[rti_pkg::DOT_W-1] ||
                    (uv_sum > (rti_pkg::DOT_W+1)'(adet_s)) ||
                    (tn_ff <= $signed(rti_pkg::DOT_W'(0)));
      div_in.sat  = rti_pkg::SAT_W'($unsigned(tn_ff)) >=
                    (rti_pkg::SAT_W'(adet_ff) << rti_pkg::SAT_SHIFT);
      div_in.adet = adet_ff;
      div_in.rem  = rti_pkg::ABS_W'($unsigned(tn_ff) >> rti_pkg::SAT_SHIFT);
      div_in.low  = {tn_ff[rti_pkg::SAT_SHIFT-1:0], {rti_pkg::FRAC_BITS{1'b0}}};
   end

   // Data registers of stages 4 to 8.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
               lo_ff[k][i] <= lo_in[k][i];
               hi_ff[k][i] <= hi_in[k][i];
            end
            slo_ff[k] <= rti_pkg::SUMLO_W'(lo_ff[k][0]) + rti_pkg::SUMLO_W'(lo_ff[k][1]) +
                         rti_pkg::SUMLO_W'(lo_ff[k][2]);
            shi_ff[k] <= rti_pkg::SUMHI_W'(hi_ff[k][0]) + rti_pkg::SUMHI_W'(hi_ff[k][1]) +
                         rti_pkg::SUMHI_W'(hi_ff[k][2]);
            dot_ff[k] <= (rti_pkg::DOT_W'(shi_ff[k]) <<< rti_pkg::SPLIT) +
                         rti_pkg::DOT_W'(slo_ff[k]);
         end
         adet_ff  <= rti_pkg::ABS_W'(abs_det);
         un_ff    <= neg ? -dot_ff[1] : dot_ff[1];
         vn_ff    <= neg ? -dot_ff[2] : dot_ff[2];
         tn_ff    <= neg ? -dot_ff[3] : dot_ff[3];
         degen_ff <= degen_in;
         div_ff   <= div_in;
      end
   end

   // Valid bits for the five stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   assign out_valid = v_ff[4];
   assign out_data  = div_ff;

endmodule

// ----- design/rti_div.sv -----
// ----------------------------------------------------------------------------
// rti_div
// Restoring division of the t numerator by |det|, one quotient bit per
// register stage.
// ----------------------------------------------------------------------------
module rti_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rti_pkg::div_type           in_data,
   output logic                       out_valid,
   output rti_pkg::div_type           out_data,
   output logic [rti_pkg::Q_W-1:0]    out_quot
);

   rti_pkg::div_type            st_d [rti_pkg::DIV_STAGES+1];
   logic [rti_pkg::Q_W-1:0]     q_d  [rti_pkg::DIV_STAGES+1];
   rti_pkg::div_type            st_ff [rti_pkg::DIV_STAGES];
   logic [rti_pkg::Q_W-1:0]     q_ff  [rti_pkg::DIV_STAGES];
   logic [rti_pkg::DIV_STAGES-1:0] v_ff;

   assign st_d[0] = in_data;
   assign q_d[0]  = '0;

   for (genvar j = 0; j < rti_pkg::DIV_STAGES; j++) begin : g_stage
      logic [rti_pkg::ABS_W:0]   trial;
      logic [rti_pkg::ABS_W:0]   diff;
      logic                      ge;
      rti_pkg::div_type          st_in;
      logic [rti_pkg::Q_W-1:0]   q_in;

      // Bring down the next numerator bit and try a subtract.
      always_comb begin
         trial     = {st_d[j].rem, st_d[j].low[rti_pkg::Q_W-1]};
         diff      = trial - {1'b0, st_d[j].adet};
         ge        = trial >= {1'b0, st_d[j].adet};
         st_in     = st_d[j];
         st_in.rem = ge ? diff[rti_pkg::ABS_W-1:0] : trial[rti_pkg::ABS_W-1:0];
         st_in.low = {st_d[j].low[rti_pkg::Q_W-2:0], 1'b0};
         q_in      = {q_d[j][rti_pkg::Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[j] <= st_in;
            q_ff[j]  <= q_in;
         end
      end

      assign st_d[j+1] = st_ff[j];
      assign q_d[j+1]  = q_ff[j];
   end

   // Valid bits for the quotient stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[rti_pkg::DIV_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[rti_pkg::DIV_STAGES-1];
   assign out_data  = st_d[rti_pkg::DIV_STAGES];
   assign out_quot  = q_d[rti_pkg::DIV_STAGES];

endmodule

// ----- design/ray_triangle_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Stages from an accepted request to its result: 3 cross stages, 5 dot and
// test stages, 31 quotient stages, 1 output register.
// Throughput: one request per cycle; a stalled output freezes the whole pipe.
// Reset (synchronous) empties the pipeline and loads the ray registers with
// origin 0, direction +z and the default epsilon.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rti_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rti_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [rti_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rti_pkg::EPS_W-1:0]       csr_wdata
);

   rti_pkg::ray_type               ray_ff;
   logic [rti_pkg::EPS_W-1:0]      eps_ff;

   logic                           en;
   logic                           geom_valid;
   rti_pkg::geom_type              geom;
   logic                           div_valid;
   rti_pkg::div_type               div_seed;
   logic                           quot_valid;
   rti_pkg::div_type               div_end;
   logic [rti_pkg::Q_W-1:0]        quot;

   rti_pkg::rsp_type               rsp_in;
   rti_pkg::rsp_type               rsp_ff;
   logic                           rsp_valid_ff;

   // The pipeline moves whenever the output register can take a result.
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff.org    <= '0;
         ray_ff.dir[0] <= '0;
         ray_ff.dir[1] <= '0;
         ray_ff.dir[2] <= rti_pkg::DIR_Z_RESET;
         eps_ff        <= rti_pkg::EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rti_pkg::CSR_ORG_X: ray_ff.org[0] <= csr_wdata[rti_pkg::COORD_W-1:0];
            rti_pkg::CSR_ORG_Y: ray_ff.org[1] <= csr_wdata[rti_pkg::COORD_W-1:0];
            rti_pkg::CSR_ORG_Z: ray_ff.org[2] <= csr_wdata[rti_pkg::COORD_W-1:0];
            rti_pkg::CSR_DIR_X: ray_ff.dir[0] <= csr_wdata[rti_pkg::COORD_W-1:0];
            rti_pkg::CSR_DIR_Y: ray_ff.dir[1] <= csr_wdata[rti_pkg::COORD_W-1:0];
            rti_pkg::CSR_DIR_Z: ray_ff.dir[2] <= csr_wdata[rti_pkg::COORD_W-1:0];
            rti_pkg::CSR_EPS:   eps_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   rti_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .ray       (ray_ff),
      .out_valid (geom_valid),
      .out_data  (geom)
   );

   rti_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geom_valid),
      .in_data   (geom),
      .ray       (ray_ff),
      .eps       (eps_ff),
      .out_valid (div_valid),
      .out_data  (div_seed)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_seed),
      .out_valid (quot_valid),
      .out_data  (div_end),
      .out_quot  (quot)
   );

   // Final hit decision: a zero truncated distance is a miss.
   always_comb begin
      rsp_in.hit = !div_end.miss && (div_end.sat || (quot != '0));
      if (!rsp_in.hit) begin
         rsp_in.hit_distance = '0;
      end else if (div_end.sat) begin
         rsp_in.hit_distance = '1;
      end else begin
         rsp_in.hit_distance = quot;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= quot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
